FILE: rtl/mcwd_pkg.sv
package mcwd_pkg;

  localparam int unsigned IdW       = 16;
  localparam int unsigned TmoW      = 32;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 2;

  // Stream packing: input word carries id then timeout, output word id then status.
  localparam int unsigned SDataW    = 48;
  localparam int unsigned MDataW    = 24;
  localparam int unsigned MPadW     = MDataW - IdW - StatusW;

  // Cap on expiry words per tick.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_KICK   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [KindW-1:0] {
    KIND_DONE      = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_QUIET     = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 2'd0,
    STS_DUPLICATE = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [TmoW-1:0] tmo;
    logic [TmoW-1:0] last;
  } entry_t;

endpackage

FILE: rtl/mcwd_ram.sv
module mcwd_ram #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/multi_channel_watchdog_table.sv
// Channel   Dir  tdata (low bit up)                 tuser   tlast
// s_axis    in   watch_id[15:0], timeout[47:16]     func    -
// m_axis    out  expired_id[15:0], status[17:16]    kind    last word of this command
//
// A command walks the table entries one at a time in ST_SCAN; a tick visits every entry,
// an add that fits writes the new entry in ST_ADD_WR, and a remove moves each entry above
// the removed one down by one slot in ST_SHIFT.
// The single table RAM port pair (one read, one write per cycle) sets this pace.
// Reset clears the entry count and time counter; the table RAM is never cleared.
// Output stalls hold ST_FIN, and a tick scan at an expiry while an earlier one is waiting.
module multi_channel_watchdog_table #(
  parameter int unsigned MAX_WATCHES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mcwd_pkg::SDataW-1:0]    s_axis_tdata,   // watch_id, timeout_ticks
  input  logic [mcwd_pkg::FuncW-1:0]     s_axis_tuser,   // func

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mcwd_pkg::MDataW-1:0]    m_axis_tdata,   // expired_id, status, zero pad
  output logic [mcwd_pkg::KindW-1:0]     m_axis_tuser,   // kind
  output logic                           m_axis_tlast    // last_result
);

  import mcwd_pkg::*;

  localparam int unsigned IdxW = (MAX_WATCHES > 1) ? $clog2(MAX_WATCHES) : 1;
  localparam int unsigned CntW = $clog2(MAX_WATCHES + 1);
  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_ADD_WR = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [IdW-1:0]      id_q, id_d;
  logic [TmoW-1:0]     tmo_q, tmo_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [TmoW-1:0]     now_q, now_d;
  logic [ResCntW-1:0]  nexp_q, nexp_d;
  logic                pend_vld_q, pend_vld_d;
  logic [IdW-1:0]      pend_id_q, pend_id_d;
  status_e             status_q, status_d;

  logic                out_vld_q, out_vld_d;
  kind_e               out_kind_q, out_kind_d;
  logic [IdW-1:0]      out_id_q, out_id_d;
  status_e             out_sts_q, out_sts_d;
  logic                out_last_q, out_last_d;

  // Table RAM ports
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  entry_t              ram_wdata;
  logic [IdxW-1:0]     ram_raddr;
  entry_t              rd;
  logic [EntryW-1:0]   ram_rdata;

  logic                can_push;
  logic                push;
  logic                in_acc;
  logic [CntW-1:0]     idx_ext;
  logic                is_last;
  logic                more_shift;
  logic                has_next;
  logic                hit;
  logic [TmoW-1:0]     elapsed;
  logic                expired;
  logic [CntW-1:0]     rd_base;

  assign rd        = entry_t'(ram_rdata);
  assign can_push  = !out_vld_q || m_axis_tready;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign idx_ext   = CntW'(idx_q);
  assign is_last   = (idx_ext + CntW'(1)) == cnt_q;
  assign has_next  = (idx_ext + CntW'(1)) < cnt_q;
  assign more_shift = (idx_ext + CntW'(2)) < cnt_q;
  assign hit       = rd.id == id_q;
  assign elapsed   = now_q - rd.last;
  assign expired   = (elapsed >= rd.tmo) && (nexp_q < ResCntW'(MaxResults));

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    id_d       = id_q;
    tmo_d      = tmo_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    nexp_d     = nexp_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    status_d   = status_q;

    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = rd;

    push       = 1'b0;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_sts_d  = out_sts_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d     = func_e'(s_axis_tuser);
          id_d       = s_axis_tdata[IdW-1:0];
          tmo_d      = s_axis_tdata[IdW +: TmoW];
          idx_d      = '0;
          nexp_d     = '0;
          pend_vld_d = 1'b0;
          status_d   = STS_OK;
          unique case (func_e'(s_axis_tuser))
            FUNC_TICK: begin
              now_d   = now_q + TmoW'(1);
              state_d = (cnt_q == '0) ? ST_FIN : ST_SCAN;
            end
            FUNC_ADD: begin
              if (cnt_q == CntW'(MAX_WATCHES)) begin
                status_d = STS_FULL;
                state_d  = ST_FIN;
              end else if (cnt_q == '0) begin
                state_d  = ST_ADD_WR;
              end else begin
                state_d  = ST_SCAN;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                status_d = STS_NOT_FOUND;
                state_d  = ST_FIN;
              end else begin
                state_d  = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        unique case (func_q)
          FUNC_TICK: begin
            if (expired && pend_vld_q && !can_push) begin
              // hold: previous expiry still waiting for the output register
            end else begin
              if (expired) begin
                if (pend_vld_q) begin
                  push       = 1'b1;
                  out_kind_d = KIND_EXPIRED;
                  out_id_d   = pend_id_q;
                  out_sts_d  = STS_OK;
                  out_last_d = 1'b0;
                end
                ram_we     = 1'b1;
                ram_wdata  = '{id: rd.id, tmo: rd.tmo, last: now_q};
                pend_vld_d = 1'b1;
                pend_id_d  = rd.id;
                nexp_d     = nexp_q + ResCntW'(1);
              end
              if (is_last) begin
                state_d = ST_FIN;
              end else begin
                idx_d = idx_q + IdxW'(1);
              end
            end
          end
          FUNC_ADD: begin
            if (hit) begin
              status_d = STS_DUPLICATE;
              state_d  = ST_ADD_WR;
            end else if (is_last) begin
              state_d  = ST_ADD_WR;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          FUNC_KICK: begin
            if (hit) begin
              ram_we    = 1'b1;
              ram_wdata = '{id: rd.id, tmo: rd.tmo, last: now_q};
              state_d   = ST_FIN;
            end else if (is_last) begin
              status_d = STS_NOT_FOUND;
              state_d  = ST_FIN;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          FUNC_REMOVE: begin
            if (hit) begin
              if (has_next) begin
                state_d = ST_SHIFT;
              end else begin
                cnt_d   = cnt_q - CntW'(1);
                state_d = ST_FIN;
              end
            end else if (is_last) begin
              status_d = STS_NOT_FOUND;
              state_d  = ST_FIN;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
        endcase
      end

      ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IdxW-1:0];
        ram_wdata = '{id: id_q, tmo: tmo_q, last: now_q};
        cnt_d     = cnt_q + CntW'(1);
        state_d   = ST_FIN;
      end

      ST_SHIFT: begin
        // move the entry above down by one slot
        ram_we    = 1'b1;
        ram_wdata = rd;
        if (more_shift) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (can_push) begin
          push       = 1'b1;
          out_last_d = 1'b1;
          out_id_d   = '0;
          out_sts_d  = STS_OK;
          if (func_q == FUNC_TICK) begin
            if (pend_vld_q) begin
              out_kind_d = KIND_EXPIRED;
              out_id_d   = pend_id_q;
            end else begin
              out_kind_d = KIND_QUIET;
            end
          end else begin
            out_kind_d = KIND_DONE;
            out_sts_d  = status_q;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read one slot ahead of the write while moving entries down.
  assign rd_base   = CntW'(idx_d) + ((state_d == ST_SHIFT) ? CntW'(1) : CntW'(0));
  assign ram_raddr = rd_base[IdxW-1:0];

  assign out_vld_d = push ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      now_q      <= '0;
      nexp_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      nexp_q     <= nexp_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    id_q       <= id_d;
    tmo_q      <= tmo_d;
    idx_q      <= idx_d;
    pend_id_q  <= pend_id_d;
    status_q   <= status_d;
    if (push) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_sts_q  <= out_sts_d;
      out_last_q <= out_last_d;
    end
  end

  mcwd_ram #(
    .Width (EntryW),
    .Depth (MAX_WATCHES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{MPadW{1'b0}}, out_sts_q, out_id_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import mcwd_pkg::*;

  localparam int unsigned Slots      = 16;
  localparam int unsigned RandCmds   = 154;
  localparam int unsigned CalmTail   = 30;     // last words go out with no idling
  localparam int unsigned DrainWait  = 40;     // cycles to watch for stray words at the end
  localparam int unsigned CycleLimit = 400000;

  // One command word as the sender queues it.
  typedef struct {
    func_e           func;
    logic [IdW-1:0]  id;
    logic [TmoW-1:0] tmo;
    bit              hold;   // present only after every pending reply has come back
  } cmd_t;

  // One reply word as the table should produce it.
  typedef struct {
    kind_e          kind;
    logic [IdW-1:0] id;
    status_e        status;
    logic           last;
  } reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SDataW-1:0]    s_axis_tdata = '0;    // watch_id[15:0], timeout_ticks[47:16]
  logic [FuncW-1:0]     s_axis_tuser = '0;    // func

  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [MDataW-1:0]    m_axis_tdata;         // expired_id[15:0], status[17:16], pad[23:18]
  logic [KindW-1:0]     m_axis_tuser;         // kind
  logic                 m_axis_tlast;         // last_result

  cmd_t                 cmd_q[$];
  reply_t               reply_q[$];

  // Shadow of the watch table.
  entry_t               shadow_tbl[Slots];
  int unsigned          shadow_cnt;
  logic [TmoW-1:0]      shadow_now;

  int unsigned          send_gap;
  int unsigned          recv_stall;
  int unsigned          errors;
  int unsigned          cycles;
  int unsigned          words_sent;
  int unsigned          words_seen;
  int unsigned          expiries_seen;
  int unsigned          quiet_seen;
  int unsigned          status_seen[4];

  multi_channel_watchdog_table #(
    .MAX_WATCHES(Slots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Queue one command for the sender.
  function automatic void queue_cmd(func_e f, logic [IdW-1:0] id, logic [TmoW-1:0] tmo,
                                    bit hold = 1'b0);
    cmd_t c;
    c.func = f;
    c.id   = id;
    c.tmo  = tmo;
    c.hold = hold;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_reply(kind_e k, logic [IdW-1:0] id, status_e s, logic last);
    reply_t r;
    r.kind   = k;
    r.id     = id;
    r.status = s;
    r.last   = last;
    reply_q.push_back(r);
  endfunction

  // Index of the first entry with this id, or the entry count when absent.
  function automatic int unsigned find_watch(logic [IdW-1:0] id);
    for (int unsigned i = 0; i < shadow_cnt; i++) begin
      if (shadow_tbl[i].id == id) return i;
    end
    return shadow_cnt;
  endfunction

  // Apply one accepted command to the shadow table and queue the replies it owes.
  function automatic void update_table(cmd_t c);
    int unsigned pos;
    int unsigned fired;
    status_e     sts;
    reply_t      held;
    bit          have_held;
    logic [TmoW-1:0] elapsed;

    sts = STS_OK;
    if (c.func == FUNC_TICK) begin
      shadow_now = shadow_now + 1'b1;
      fired      = 0;
      have_held  = 1'b0;
      for (int unsigned i = 0; i < shadow_cnt; i++) begin
        elapsed = shadow_now - shadow_tbl[i].last;
        if (elapsed >= shadow_tbl[i].tmo && fired < MaxResults) begin
          // Hold each expiry back one step so the final one can carry last.
          if (have_held) reply_q.push_back(held);
          held.kind   = KIND_EXPIRED;
          held.id     = shadow_tbl[i].id;
          held.status = STS_OK;
          held.last   = 1'b0;
          have_held   = 1'b1;
          shadow_tbl[i].last = shadow_now;
          fired++;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        reply_q.push_back(held);
      end else begin
        push_reply(KIND_QUIET, '0, STS_OK, 1'b1);
      end
      return;
    end

    pos = find_watch(c.id);
    case (c.func)
      FUNC_ADD: begin
        if (shadow_cnt >= Slots) begin
          sts = STS_FULL;
        end else begin
          if (pos < shadow_cnt) sts = STS_DUPLICATE;
          shadow_tbl[shadow_cnt].id   = c.id;
          shadow_tbl[shadow_cnt].tmo  = c.tmo;
          shadow_tbl[shadow_cnt].last = shadow_now;
          shadow_cnt++;
        end
      end
      FUNC_KICK: begin
        if (pos < shadow_cnt) shadow_tbl[pos].last = shadow_now;
        else sts = STS_NOT_FOUND;
      end
      default: begin
        if (pos < shadow_cnt) begin
          // Close the hole, keeping the later entries in order.
          for (int unsigned i = pos; i + 1 < shadow_cnt; i++) begin
            shadow_tbl[i] = shadow_tbl[i + 1];
          end
          shadow_cnt--;
        end else begin
          sts = STS_NOT_FOUND;
        end
      end
    endcase
    push_reply(KIND_DONE, '0, sts, 1'b1);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted reply word against the oldest expectation.
  function automatic void check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual kind %0d id %0h status %0d last %0b",
               $time, m_axis_tuser, m_axis_tdata[IdW-1:0], m_axis_tdata[IdW+:StatusW],
               m_axis_tlast);
      errors++;
      return;
    end
    want = reply_q.pop_front();
    check_field("kind", want.kind, m_axis_tuser);
    check_field("expired_id", want.id, m_axis_tdata[IdW-1:0]);
    check_field("status", want.status, m_axis_tdata[IdW+:StatusW]);
    check_field("pad", 0, m_axis_tdata[MDataW-1:IdW+StatusW]);
    check_field("last", want.last, m_axis_tlast);
    words_seen++;
    if (want.kind == KIND_EXPIRED) expiries_seen++;
    if (want.kind == KIND_QUIET) quiet_seen++;
    if (want.kind == KIND_DONE) status_seen[want.status]++;
  endfunction

  // Sender: predict on acceptance, then hold, idle or advance to the next word.
  always @(posedge clk_i) begin
    bit next_valid;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        update_table(cmd_q[0]);
        void'(cmd_q.pop_front());
        words_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].hold && reply_q.size() > 0)) begin
          if (cmd_q.size() > CalmTail && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 16);
          end else begin
            next_valid = 1'b1;
            s_axis_tdata <= {cmd_q[0].tmo, cmd_q[0].id};
            s_axis_tuser <= cmd_q[0].func;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Receiver: check each accepted word, stall in random bursts until the tail.
  always @(posedge clk_i) begin
    bit next_ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (recv_stall > 0) begin
        recv_stall--;
        next_ready = 1'b0;
      end else if (cmd_q.size() > CalmTail && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(0, 16);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d commands and %0d replies pending",
               $time, cmd_q.size(), reply_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Pick an id: mostly a small pool so duplicates and hits are common.
  function automatic logic [IdW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return IdW'($urandom_range(0, 7));
    if (r < 80) return '1;
    return IdW'($urandom());
  endfunction

  // Pick a timeout: mostly short so entries expire within the run.
  function automatic logic [TmoW-1:0] pick_tmo();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return TmoW'($urandom_range(0, 6));
    if (r < 80) return TmoW'($urandom_range(0, 40));
    return TmoW'($urandom());
  endfunction

  initial begin
    int unsigned r;
    int unsigned add_w;
    int unsigned rem_w;
    func_e       f;

    shadow_cnt = 0;
    shadow_now = '0;
    send_gap   = 0;
    recv_stall = 0;
    errors     = 0;
    cycles     = 0;
    words_sent = 0;
    words_seen = 0;
    expiries_seen = 0;
    quiet_seen = 0;
    status_seen = '{default: 0};

    // Directed: empty tick, id and timeout extremes, duplicate, misses, first-match remove.
    queue_cmd(FUNC_TICK, '0, '0);
    queue_cmd(FUNC_ADD, 16'h0000, 32'h0000_0000);
    queue_cmd(FUNC_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    queue_cmd(FUNC_ADD, 16'h0000, 32'd2);
    queue_cmd(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    queue_cmd(FUNC_KICK, 16'h0000, 32'hFFFF_FFFF);
    queue_cmd(FUNC_KICK, 16'h1234, '0);
    queue_cmd(FUNC_REMOVE, 16'h4321, '0);
    queue_cmd(FUNC_REMOVE, 16'h0000, '0);
    queue_cmd(FUNC_TICK, '0, '0);
    // Fill the table with zero timeouts, overflow it, then tick so every zero-timeout entry expires.
    for (int unsigned k = 0; k < Slots - 2; k++) begin
      queue_cmd(FUNC_ADD, IdW'(16'h0100 + k), '0);
    end
    queue_cmd(FUNC_ADD, 16'h0A5A, 32'd5);
    queue_cmd(FUNC_TICK, '0, '0);

    // Random: fill-heavy, then balanced, then drain-heavy; ticks throughout.
    for (int unsigned k = 0; k < RandCmds; k++) begin
      if (k < RandCmds / 3) begin
        add_w = 45; rem_w = 10;
      end else if (k < 2 * RandCmds / 3) begin
        add_w = 25; rem_w = 25;
      end else begin
        add_w = 10; rem_w = 40;
      end
      r = $urandom_range(0, 99);
      if (r < add_w) f = FUNC_ADD;
      else if (r < add_w + rem_w) f = FUNC_REMOVE;
      else if (r < add_w + rem_w + 15) f = FUNC_KICK;
      else f = FUNC_TICK;
      queue_cmd(f, pick_id(), (f == FUNC_ADD) ? pick_tmo() : TmoW'($urandom()),
                k == RandCmds / 2);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (reply_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d replies: %0d expiries, %0d quiet ticks",
             words_sent, words_seen, expiries_seen, quiet_seen);
    $display("Command status counts: ok %0d, duplicate %0d, not found %0d, full %0d",
             status_seen[STS_OK], status_seen[STS_DUPLICATE], status_seen[STS_NOT_FOUND],
             status_seen[STS_FULL]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
